// ===== design/skgr_pkg.sv =====
package skgr_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned GS_W   = 5;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     list_end;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element_out;
    logic                     burst_last;
    logic                     list_end_out;
  } out_item_t;

endpackage

// ===== design/stream_k_group_reverser_top.sv =====
// Stream k-group reverser. Each input transaction carries one list element
// and a list_end flag. Elements are written into a single MAX_GROUP-entry
// synchronous memory until group_size of them are held. The group is then
// read back in reverse order as a burst of output transactions. If the list
// ends with fewer than group_size elements held, the leftovers are read back
// in their original order. burst_last marks the final output of each burst,
// and list_end_out marks the final output of the list. Each output
// transaction's data comes straight from the memory's registered read port.
// Flow: an element that does not close a group is written and the input
// stays ready. An element that closes a group of n elements is written,
// then the group is read back one read a cycle through the memory's port
// while the output does not stall. in_stall_o stays high while the burst is
// read out. The next element is taken while the last output of a burst still waits.
// group_size is written through cfg_we_i/cfg_data_i. A value of 0 acts as
// 1 (pass-through), and values above MAX_GROUP act as MAX_GROUP. Write it
// only while no burst is being read out. A size lowered while elements are
// held takes effect on the next element: if the buffer then holds at least
// the new size, everything held is emitted reversed as one group.
module stream_k_group_reverser_top
  import skgr_pkg::*;
#(
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [GS_W-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o
);

  localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int unsigned CW = $clog2(MAX_GROUP + 1);
  localparam int unsigned KW = (CW > GS_W) ? CW : GS_W;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  // Group buffer storage and its registered read port.
  logic [ELEM_W-1:0] mem_q [MAX_GROUP];
  logic [ELEM_W-1:0] rd_data_q;

  logic            state_q, state_d;
  logic [GS_W-1:0] group_size_q;
  logic [CW-1:0]   fill_q, fill_d;
  logic [CW-1:0]   rd_cnt_q, rd_cnt_d;
  logic [AW-1:0]   rd_idx_q, rd_idx_d;
  logic            reverse_q, reverse_d;
  logic            last_q, last_d;
  logic            out_valid_q, out_valid_d;
  logic            out_burst_last_q;
  logic            out_list_end_q;

  logic          in_fire;
  logic          rd_fire;
  logic          group_done;
  logic [CW-1:0] fill_inc;
  logic [KW-1:0] gs_ext;
  logic [KW-1:0] k_eff;

  // Clamp the programmed group size to 1..MAX_GROUP.
  always_comb begin
    gs_ext = KW'(group_size_q);
    if (gs_ext == '0) begin
      k_eff = KW'(1);
    end else if (gs_ext > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end else begin
      k_eff = gs_ext;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign fill_inc   = fill_q + CW'(1);
  assign group_done = (KW'(fill_inc) >= k_eff);

  // In drain, issue a read whenever the output register is free or being emptied.
  assign rd_fire = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_cnt_d    = rd_cnt_q;
    rd_idx_d    = rd_idx_q;
    reverse_d   = reverse_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (group_done || in_data_i.list_end) begin
            // Close the group: reverse a full group, keep leftovers in order.
            state_d   = ST_DRAIN;
            fill_d    = '0;
            rd_cnt_d  = fill_inc;
            reverse_d = group_done;
            last_d    = in_data_i.list_end;
            rd_idx_d  = group_done ? fill_q[AW-1:0] : '0;
          end else begin
            fill_d = fill_inc;
          end
        end
      end
      ST_DRAIN: begin
        if (rd_fire) begin
          out_valid_d = 1'b1;
          rd_cnt_d    = rd_cnt_q - CW'(1);
          rd_idx_d    = reverse_q ? (rd_idx_q - AW'(1)) : (rd_idx_q + AW'(1));
          if (rd_cnt_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      group_size_q     <= GS_W'(1);
      fill_q           <= '0;
      rd_cnt_q         <= '0;
      rd_idx_q         <= '0;
      reverse_q        <= 1'b0;
      last_q           <= 1'b0;
      out_valid_q      <= 1'b0;
      out_burst_last_q <= 1'b0;
      out_list_end_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_idx_q    <= rd_idx_d;
      reverse_q   <= reverse_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        group_size_q <= cfg_data_i;
      end
      if (rd_fire) begin
        // Tag the final read of the burst.
        out_burst_last_q <= (rd_cnt_q == CW'(1));
        out_list_end_q   <= (rd_cnt_q == CW'(1)) && last_q;
      end
    end
  end

  // Write port: store the accepted element at the next free entry.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mem_q[fill_q[AW-1:0]] <= in_data_i.element;
    end
  end

  // Read port: hold the read register while the output is stalled.
  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.element_out  = rd_data_q;
  assign out_data_o.burst_last   = out_burst_last_q;
  assign out_data_o.list_end_out = out_list_end_q;

endmodule

// ===== design/skgr_checker.sv =====
module skgr_checker
  import skgr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // Hold a stalled output transaction unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  // End of list only on the final output of a burst.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.list_end_out |-> out_data_o.burst_last)
    else $error("list_end_out without burst_last");

  // A list end always starts a burst, so the input stalls next cycle.
  a_end_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.list_end |=> in_stall_o)
    else $error("list end accepted without draining");

  // A burst continues without gaps once a non-final output is taken.
  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.burst_last |=> out_valid_o)
    else $error("gap inside an output burst");

endmodule

bind stream_k_group_reverser_top skgr_checker u_skgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
